FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of the median filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`endif

FILE: hdl/mf3_pkg.sv
// Shared constants, types and sorting functions of the 3x3 median filter.
package mf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 12;
   localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
   localparam int PIX_W      = 8;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int CREDIT_W   = FIFO_CW + 1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd320;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 12'd240;
   localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 11'd3;
   localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 12'd3;

   typedef logic [PIX_W-1:0] pixel_type;

   // [row][column], column 2 is the newest
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic frame_end;
   } flags_type;

   typedef struct packed {
      logic             valid;
      flags_type        flags;
      logic [COL_W-1:0] addr;
      pixel_type        pixel;
   } push_type;

   typedef struct packed {
      logic      valid;
      logic      frame_end;
      pixel_type pixel;
   } result_type;

   typedef struct packed {
      pixel_type lo;
      pixel_type mid;
      pixel_type hi;
   } sort3_type;

   function automatic sort3_type sort3(pixel_type a, pixel_type b, pixel_type c);
      pixel_type x;
      pixel_type y;
      sort3_type s;
      x = (a < b) ? a : b;
      y = (a < b) ? b : a;
      s.lo  = (x < c) ? x : c;
      s.hi  = (y > c) ? y : c;
      s.mid = (x > ((y < c) ? y : c)) ? x : ((y < c) ? y : c);
      return s;
   endfunction

   function automatic pixel_type med3(pixel_type a, pixel_type b, pixel_type c);
      sort3_type s;
      s = sort3(a, b, c);
      return s.mid;
   endfunction

endpackage

FILE: hdl/median_filter_3x3_stream.sv
// A released result passes the line-store, window, sort and queue registers; results trail the
// pixel stream by one image line plus one pixel, drained at frame end by flush transfers.
// Throughput: one transfer per cycle; the line stores have one read and one write port, and
// req_tready drops only in reset or while eight results are queued or in flight.
// Reset clears counters, window, pipeline flags and queue, and sets width 320 and height 240;
// the line stores are not cleared and need no clearing pass.
module median_filter_3x3_stream (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mf3_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   input  logic                           req_tuser,   // [0] flush
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mf3_pkg::PIX_W-1:0]      rsp_tdata,   // [7:0] pixel_out
   output logic                           rsp_tlast    // frame_end
);
   import mf3_pkg::*;

   push_type              push;
   logic                  s1_emit;
   window_type            win;
   flags_type             win_flags;
   logic                  s3_emit;
   result_type            result;
   logic [FIFO_CW-1:0]    count;
   logic [CREDIT_W-1:0]   in_flight;

   // queued plus in-flight results must leave room for one more
   assign in_flight = CREDIT_W'(count) + CREDIT_W'(s1_emit) + CREDIT_W'(win_flags.emit)
                    + CREDIT_W'(s3_emit);
   assign req_tready = ~reset & (in_flight < CREDIT_W'(FIFO_DEPTH));

   mf3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push)
   );

   mf3_line_buf u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .s1_emit   (s1_emit),
      .win       (win),
      .win_flags (win_flags)
   );

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .win_flags (win_flags),
      .s3_emit   (s3_emit),
      .result    (result)
   );

   mf3_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .count      (count)
   );

endmodule

FILE: hdl/mf3_ctrl.sv
// Position counters, frame restart and transfer decode of the median filter.
module mf3_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [mf3_pkg::PIX_W-1:0]      req_tdata,
   input  logic                           req_tuser,
   output mf3_pkg::push_type              push
);
   import mf3_pkg::*;

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [HEIGHT_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [PEND_W-1:0]   pending_ff, pending_in;

   logic                accept;
   logic                at_start;
   logic                pend_full;
   logic                flush_go;
   logic                drop;
   logic                emit;
   logic [WIDTH_W-1:0]  in_col_inc;
   logic [WIDTH_W-1:0]  out_col_inc;
   logic [HEIGHT_W-1:0] in_row_inc;
   logic [HEIGHT_W-1:0] out_row_inc;
   logic [COL_W-1:0]    flush_col;
   logic [COL_W-1:0]    out_col_adv;
   logic [HEIGHT_W-1:0] out_row_adv;
   logic [COL_W-1:0]    in_col_adv;
   logic [HEIGHT_W-1:0] in_row_adv;
   logic                interior;
   logic                frame_end;
   logic [WIDTH_W-1:0]  raw_width;
   logic [HEIGHT_W-1:0] raw_height;

   assign accept   = req_tvalid & req_tready;
   assign at_start = (in_row_ff == '0) && (in_col_ff == '0);
   assign pend_full = (pending_ff == PEND_W'(width_ff + WIDTH_W'(1)));
   assign flush_go = req_tuser & at_start & (pending_ff != '0);
   // a new frame that starts on a partly drained tail drops the rest
   assign drop     = ~req_tuser & at_start & (pending_ff != '0) & ~pend_full;
   assign emit     = req_tuser ? flush_go : pend_full;

   assign in_col_inc  = WIDTH_W'(in_col_ff) + WIDTH_W'(1);
   assign out_col_inc = WIDTH_W'(out_col_ff) + WIDTH_W'(1);
   assign in_row_inc  = in_row_ff + HEIGHT_W'(1);
   assign out_row_inc = out_row_ff + HEIGHT_W'(1);

   assign flush_col = (out_col_inc == width_ff) ? '0 : out_col_inc[COL_W-1:0];

   always_comb begin
      in_col_adv = in_col_inc[COL_W-1:0];
      in_row_adv = in_row_ff;
      if (in_col_inc >= width_ff) begin
         in_col_adv = '0;
         in_row_adv = (in_row_inc >= height_ff) ? '0 : in_row_inc;
      end
      out_col_adv = out_col_inc[COL_W-1:0];
      out_row_adv = out_row_ff;
      if (out_col_inc >= width_ff) begin
         out_col_adv = '0;
         out_row_adv = (out_row_inc >= height_ff) ? '0 : out_row_inc;
      end
   end

   assign interior = (out_row_ff != '0)
                   && ((HEIGHT_W + 1)'(out_row_ff) + (HEIGHT_W + 1)'(2)
                       <= (HEIGHT_W + 1)'(height_ff))
                   && (out_col_ff != '0)
                   && (out_col_inc + WIDTH_W'(1) <= width_ff);
   assign frame_end = (out_row_ff == height_ff - HEIGHT_W'(1))
                   && (out_col_inc == width_ff);

   assign raw_width  = csr_wdata[WIDTH_W-1:0];
   assign raw_height = csr_wdata[HEIGHT_W-1:0];

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pending_in = pending_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (raw_width < MIN_WIDTH) begin
                  width_in = MIN_WIDTH;
               end else if (raw_width > MAX_WIDTH_V) begin
                  width_in = MAX_WIDTH_V;
               end else begin
                  width_in = raw_width;
               end
            end
            REG_IMAGE_HEIGHT: begin
               height_in = (raw_height < MIN_HEIGHT) ? MIN_HEIGHT : raw_height;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
         // restart the frame, drop pending results
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pending_in = '0;
      end else if (accept) begin
         if (req_tuser) begin
            if (flush_go) begin
               pending_in = pending_ff - PEND_W'(1);
               out_col_in = out_col_adv;
               out_row_in = out_row_adv;
            end
         end else begin
            in_col_in = in_col_adv;
            in_row_in = in_row_adv;
            if (drop) begin
               out_col_in = '0;
               out_row_in = '0;
               pending_in = PEND_W'(1);
            end else if (pend_full) begin
               out_col_in = out_col_adv;
               out_row_in = out_row_adv;
            end else begin
               pending_in = pending_ff + PEND_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RESET_WIDTH;
         height_ff  <= RESET_HEIGHT;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pending_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pending_ff <= pending_in;
      end
   end

   always_comb begin
      push.valid           = accept & (~req_tuser | flush_go);
      push.flags.emit      = accept & emit;
      push.flags.interior  = interior;
      push.flags.frame_end = frame_end;
      push.addr            = req_tuser ? flush_col : in_col_ff;
      push.pixel           = req_tuser ? '0 : req_tdata;
   end

endmodule

FILE: hdl/mf3_line_buf.sv
// Two line stores with read bypass and the 3x3 window register.
module mf3_line_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  mf3_pkg::push_type    push,
   output logic                 s1_emit,
   output mf3_pkg::window_type  win,
   output mf3_pkg::flags_type   win_flags
);
   import mf3_pkg::*;

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   logic             s1_valid_ff;
   flags_type        s1_flags_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pixel_type        s1_pix_ff;
   pixel_type        rd_top_ff;
   pixel_type        rd_mid_ff;
   logic             byp_ff;
   pixel_type        byp_top_ff;
   pixel_type        byp_mid_ff;
   window_type       win_ff, win_in;
   flags_type        win_flags_ff;

   pixel_type top_val;
   pixel_type mid_val;
   logic      byp_hit;

   // the previous item writes the column this one reads: take its data
   assign top_val = byp_ff ? byp_top_ff : rd_top_ff;
   assign mid_val = byp_ff ? byp_mid_ff : rd_mid_ff;
   assign byp_hit = push.valid & s1_valid_ff & (s1_addr_ff == push.addr);

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rd_top_ff <= upper_mem[push.addr];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_addr_ff] <= mid_val;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rd_mid_ff <= middle_mem[push.addr];
      end
      if (s1_valid_ff) begin
         middle_mem[s1_addr_ff] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         s1_addr_ff <= push.addr;
         s1_pix_ff  <= push.pixel;
         byp_top_ff <= mid_val;
         byp_mid_ff <= s1_pix_ff;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = top_val;
         win_in[1][2] = mid_val;
         win_in[2][2] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_flags_ff  <= '0;
         byp_ff       <= 1'b0;
         win_ff       <= '0;
         win_flags_ff <= '0;
      end else begin
         s1_valid_ff <= push.valid;
         s1_flags_ff <= push.flags;
         if (push.valid) begin
            byp_ff <= byp_hit;
         end
         win_ff                 <= win_in;
         win_flags_ff.emit      <= s1_valid_ff & s1_flags_ff.emit;
         win_flags_ff.interior  <= s1_flags_ff.interior;
         win_flags_ff.frame_end <= s1_flags_ff.frame_end;
      end
   end

   assign s1_emit   = s1_valid_ff & s1_flags_ff.emit;
   assign win       = win_ff;
   assign win_flags = win_flags_ff;

endmodule

FILE: hdl/mf3_median.sv
// Two-stage median-of-nine network with border pass-through.
module mf3_median (
   input  logic                 clock,
   input  logic                 reset,
   input  mf3_pkg::window_type  win,
   input  mf3_pkg::flags_type   win_flags,
   output logic                 s3_emit,
   output mf3_pkg::result_type  result
);
   import mf3_pkg::*;

   sort3_type row_ff [3];
   pixel_type centre_ff;
   flags_type flags_ff;

   pixel_type lo_max;
   pixel_type mid_med;
   pixel_type hi_min;
   pixel_type median;
   sort3_type lo_s;
   sort3_type hi_s;

   // sort each row; the median is med3 of the largest low, middle mid, smallest high
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         row_ff[r] <= sort3(win[r][0], win[r][1], win[r][2]);
      end
      centre_ff <= win[1][1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= win_flags;
      end
   end

   always_comb begin
      lo_s    = sort3(row_ff[0].lo, row_ff[1].lo, row_ff[2].lo);
      hi_s    = sort3(row_ff[0].hi, row_ff[1].hi, row_ff[2].hi);
      lo_max  = lo_s.hi;
      hi_min  = hi_s.lo;
      mid_med = med3(row_ff[0].mid, row_ff[1].mid, row_ff[2].mid);
      median  = med3(lo_max, mid_med, hi_min);
   end

   assign s3_emit          = flags_ff.emit;
   assign result.valid     = flags_ff.emit;
   assign result.frame_end = flags_ff.frame_end;
   assign result.pixel     = flags_ff.interior ? median : centre_ff;

endmodule

FILE: hdl/mf3_out_fifo.sv
// Result queue in front of the output channel.
module mf3_out_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  mf3_pkg::result_type            result,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [mf3_pkg::PIX_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast,
   output logic [mf3_pkg::FIFO_CW-1:0]    count
);
   import mf3_pkg::*;

   typedef struct packed {
      logic      frame_end;
      pixel_type pixel;
   } entry_type;

   entry_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   head_ff, head_in;
   logic [FIFO_AW-1:0]   tail_ff, tail_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;

   assign pop = rsp_tvalid & rsp_tready;

   always_comb begin
      head_in  = pop ? head_ff + FIFO_AW'(1) : head_ff;
      tail_in  = result.valid ? tail_ff + FIFO_AW'(1) : tail_ff;
      count_in = count_ff;
      if (result.valid && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (!result.valid && pop) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         slot_ff[tail_ff] <= '{frame_end: result.frame_end, pixel: result.pixel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = slot_ff[head_ff].pixel;
   assign rsp_tlast  = slot_ff[head_ff].frame_end;
   assign count      = count_ff;

endmodule

FILE: hdl/mf3_checker.sv
// Port-level checks of the median filter, bound to the top level.
`include "assert_macros.svh"

module mf3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mf3_pkg::PIX_W-1:0]      rsp_tdata,
   input logic                           rsp_tlast
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // reset empties the result queue
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // a result on an empty queue comes from an earlier accepted transfer
   `ASSERT_IMPL(a_rsp_origin, clock, reset, $rose(rsp_tvalid),
                $past(req_tvalid && req_tready, 4))

   // back-pressure only while results wait downstream
   `ASSERT_IMPL(a_stall_cause, clock, reset, !req_tready, rsp_tvalid)

endmodule

bind median_filter_3x3_stream mf3_checker u_mf3_checker (.*);
